/* sv/sed_pkg.sv */
// Shared types, constants and character helpers for the string escape decoder.
`timescale 1ns / 1ps

package sed_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    localparam int unsigned LENGTH_MAX_DEFAULT = 65535;
    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_ESC       = 3'd1,
        MODE_HEX_FIRST = 3'd2,
        MODE_HEX       = 3'd3,
        MODE_OCT       = 3'd4,
        MODE_ERROR     = 3'd5
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              last;
        logic              error;
        logic [LEN_W-1:0]  length;
    } result_t;

    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_QUOTE  = "'";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_QMARK  = "?";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_7      = "7";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_LC_A   = "a";
    localparam logic [7:0] CH_LC_B   = "b";
    localparam logic [7:0] CH_LC_F   = "f";
    localparam logic [7:0] CH_LC_N   = "n";
    localparam logic [7:0] CH_LC_R   = "r";
    localparam logic [7:0] CH_LC_T   = "t";
    localparam logic [7:0] CH_LC_V   = "v";
    localparam logic [7:0] CH_LC_X   = "x";
    localparam logic [7:0] CH_UC_A   = "A";
    localparam logic [7:0] CH_UC_F   = "F";

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] off_num;
        logic [7:0] off_lc;
        logic [7:0] off_uc;
        off_num = c - CH_0;
        off_lc  = c - CH_LC_A;
        off_uc  = c - CH_UC_A;
        if (c >= CH_0 && c <= CH_9)
            return {1'b1, off_num[3:0]};
        else if (c >= CH_LC_A && c <= CH_LC_F)
            return {1'b1, 4'(off_lc[3:0] + 4'd10)};
        else if (c >= CH_UC_A && c <= CH_UC_F)
            return {1'b1, 4'(off_uc[3:0] + 4'd10)};
        else
            return 5'd0;
    endfunction

    // {valid, code}
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            CH_LC_A:   return {1'b1, 8'd7};
            CH_LC_B:   return {1'b1, 8'd8};
            CH_LC_F:   return {1'b1, 8'd12};
            CH_LC_N:   return {1'b1, 8'd10};
            CH_LC_R:   return {1'b1, 8'd13};
            CH_LC_T:   return {1'b1, 8'd9};
            CH_LC_V:   return {1'b1, 8'd11};
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_DQUOTE: return {1'b1, CH_DQUOTE};
            CH_QMARK:  return {1'b1, CH_QMARK};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            default:   return 9'd0;
        endcase
    endfunction

endpackage

/* sv/sed_in_if.sv */
// Raw character channel: one literal character per word.
`timescale 1ns / 1ps

interface sed_in_if;
    logic                       valid;
    logic                       ready;
    logic [sed_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink (input valid, in_byte, in_last, output ready);
endinterface

/* sv/sed_out_if.sv */
// Decoded channel: data bytes and end markers.
`timescale 1ns / 1ps

interface sed_out_if;
    logic                       valid;
    logic                       ready;
    logic [sed_pkg::BYTE_W-1:0] out_byte;
    logic                       out_has_byte;
    logic                       out_last;
    logic                       out_error;
    logic [sed_pkg::LEN_W-1:0]  out_length;

    modport source (output valid, out_byte, out_has_byte, out_last, out_error, out_length,
                    input ready);
    modport sink (input valid, out_byte, out_has_byte, out_last, out_error, out_length,
                  output ready);
endinterface

/* sv/string_escape_decoder_core.sv */
// Top level of the C string escape decoder: decode step and result queue.
`timescale 1ns / 1ps

// Decodes the body of a C string literal, one raw character per input word,
// into decoded bytes followed by an end marker carrying the error flag and
// the saturating decoded length (limit: smaller of LENGTH_MAX and 65535).
// Each character is decoded in the cycle it is accepted and yields zero to
// three words (a flushed hex/octal value, a plain byte, the end marker),
// which go into a four-word result queue. A character is accepted whenever
// the queue holds at most one word, so with a draining sink and characters
// of one word each one is taken every cycle; the output port moves one word
// per cycle, bounding throughput when characters average more than one word.
module string_escape_decoder_core #(
    parameter int unsigned LENGTH_MAX = sed_pkg::LENGTH_MAX_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    sed_in_if.sink           chars,
    sed_out_if.source        decoded
);

    localparam logic [sed_pkg::LEN_W-1:0] CountLimit =
        (LENGTH_MAX > 32'd65535) ? 16'hFFFF : LENGTH_MAX[sed_pkg::LEN_W-1:0];
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    sed_pkg::mode_t mode_reg, mode_next;
    logic [1:0]                 digit_reg, digit_next;
    logic [7:0]                 acc_reg, acc_next;
    logic [sed_pkg::LEN_W-1:0]  len_reg, len_next;

    sed_pkg::result_t           q_reg [QDepth];
    logic [QAw-1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [QCw-1:0]             count_reg, count_next;

    logic        accept, pop;
    logic        emit_a, emit_b, emit_m, err;
    logic [7:0]  byte_a, byte_b;
    logic [4:0]  hd;
    logic [8:0]  se;
    logic        is_oct;
    logic [1:0]  digit_inc;
    logic [sed_pkg::LEN_W-1:0] cnt_a, cnt_b;
    logic [1:0]  push_n;
    sed_pkg::result_t res_a, res_b, res_m, e0, e1, e2, head;

    assign accept = chars.valid && chars.ready;
    assign pop    = decoded.valid && decoded.ready;
    assign chars.ready = count_reg <= QCw'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        digit_next = digit_reg;
        acc_next   = acc_reg;
        emit_a     = 1'b0;
        emit_b     = 1'b0;
        byte_a     = acc_reg;
        byte_b     = chars.in_byte;
        hd         = sed_pkg::hex_digit(chars.in_byte);
        se         = sed_pkg::simple_escape(chars.in_byte);
        is_oct     = chars.in_byte >= sed_pkg::CH_0 && chars.in_byte <= sed_pkg::CH_7;
        digit_inc  = digit_reg + 2'd1;

        case (mode_reg)
            sed_pkg::MODE_ESC:
            begin
                mode_next = sed_pkg::MODE_NORMAL;
                if (se[8])
                begin
                    emit_a = 1'b1;
                    byte_a = se[7:0];
                end
                else if (chars.in_byte == sed_pkg::CH_LC_X)
                begin
                    acc_next  = 8'd0;
                    mode_next = sed_pkg::MODE_HEX_FIRST;
                end
                else if (is_oct)
                begin
                    acc_next   = {5'd0, chars.in_byte[2:0]};
                    digit_next = 2'd1;
                    mode_next  = sed_pkg::MODE_OCT;
                end
                else
                    mode_next = sed_pkg::MODE_ERROR;
            end
            sed_pkg::MODE_HEX_FIRST:
            begin
                if (hd[4])
                begin
                    acc_next  = {4'd0, hd[3:0]};
                    mode_next = sed_pkg::MODE_HEX;
                end
                else
                    mode_next = sed_pkg::MODE_ERROR;
            end
            sed_pkg::MODE_HEX:
            begin
                if (hd[4])
                    acc_next = {acc_reg[3:0], hd[3:0]};
                else
                begin
                    emit_a     = 1'b1;
                    acc_next   = 8'd0;
                    digit_next = 2'd0;
                    if (chars.in_byte == sed_pkg::CH_BSLASH)
                        mode_next = sed_pkg::MODE_ESC;
                    else
                    begin
                        mode_next = sed_pkg::MODE_NORMAL;
                        emit_b    = 1'b1;
                    end
                end
            end
            sed_pkg::MODE_OCT:
            begin
                if (is_oct)
                begin
                    acc_next   = {acc_reg[4:0], chars.in_byte[2:0]};
                    digit_next = digit_inc;
                    if (digit_inc >= sed_pkg::OCT_DIGITS_MAX)
                    begin
                        emit_a     = 1'b1;
                        byte_a     = {acc_reg[4:0], chars.in_byte[2:0]};
                        acc_next   = 8'd0;
                        digit_next = 2'd0;
                        mode_next  = sed_pkg::MODE_NORMAL;
                    end
                end
                else
                begin
                    emit_a     = 1'b1;
                    acc_next   = 8'd0;
                    digit_next = 2'd0;
                    if (chars.in_byte == sed_pkg::CH_BSLASH)
                        mode_next = sed_pkg::MODE_ESC;
                    else
                    begin
                        mode_next = sed_pkg::MODE_NORMAL;
                        emit_b    = 1'b1;
                    end
                end
            end
            sed_pkg::MODE_ERROR:
            begin
                mode_next = sed_pkg::MODE_ERROR;
            end
            default:
            begin
                mode_next = sed_pkg::MODE_NORMAL;
                if (chars.in_byte == sed_pkg::CH_BSLASH)
                    mode_next = sed_pkg::MODE_ESC;
                else
                    emit_b = 1'b1;
            end
        endcase

        // end of string: flush a pending value; a bare \x is an error
        emit_m = chars.in_last;
        err    = 1'b0;
        if (chars.in_last)
        begin
            if (mode_next == sed_pkg::MODE_HEX || mode_next == sed_pkg::MODE_OCT)
            begin
                emit_a = 1'b1;
                byte_a = acc_next;
            end
            err = mode_next == sed_pkg::MODE_HEX_FIRST || mode_next == sed_pkg::MODE_ERROR;
        end

        cnt_a = (emit_a && len_reg < CountLimit) ? len_reg + 16'd1 : len_reg;
        cnt_b = (emit_b && cnt_a < CountLimit) ? cnt_a + 16'd1 : cnt_a;
        len_next = cnt_b;

        if (chars.in_last)
        begin
            mode_next  = sed_pkg::MODE_NORMAL;
            digit_next = 2'd0;
            acc_next   = 8'd0;
            len_next   = '0;
        end

        res_a = '{data: byte_a, has_byte: 1'b1, last: 1'b0, error: 1'b0, length: '0};
        res_b = '{data: byte_b, has_byte: 1'b1, last: 1'b0, error: 1'b0, length: '0};
        res_m = '{data: 8'd0, has_byte: 1'b0, last: 1'b1, error: err, length: cnt_b};

        push_n = 2'(emit_a) + 2'(emit_b) + 2'(emit_m);
        e0 = emit_a ? res_a : (emit_b ? res_b : res_m);
        e1 = (emit_a && emit_b) ? res_b : res_m;
        e2 = res_m;

        count_next = count_reg + (accept ? QCw'(push_n) : QCw'(0)) - QCw'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sed_pkg::MODE_NORMAL;
            digit_reg  <= 2'd0;
            acc_reg    <= 8'd0;
            len_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                digit_reg  <= digit_next;
                acc_reg    <= acc_next;
                len_reg    <= len_next;
                wr_ptr_reg <= wr_ptr_reg + QAw'(push_n);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAw'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (push_n > 2'd0)
                q_reg[wr_ptr_reg] <= e0;
            if (push_n > 2'd1)
                q_reg[QAw'(wr_ptr_reg + QAw'(1))] <= e1;
            if (push_n > 2'd2)
                q_reg[QAw'(wr_ptr_reg + QAw'(2))] <= e2;
        end
    end

    assign head = q_reg[rd_ptr_reg];
    assign decoded.valid        = count_reg != '0;
    assign decoded.out_byte     = head.data;
    assign decoded.out_has_byte = head.has_byte;
    assign decoded.out_last     = head.last;
    assign decoded.out_error    = head.error;
    assign decoded.out_length   = head.length;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCw'(QDepth))
        else $error("result queue overflow");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.in_last) |=> (mode_reg == sed_pkg::MODE_NORMAL && len_reg == '0))
        else $error("state not cleared after end of string");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == sed_pkg::MODE_ERROR) |-> (!emit_a && !emit_b))
        else $error("data word after malformed escape");

    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CountLimit)
        else $error("decoded length beyond limit");

    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !accept) |=> (count_reg == $past(count_reg) - QCw'(1)))
        else $error("queue count out of step with pop");

endmodule
